/* rtl/dpc_pkg.sv */
package dpc_pkg;

    localparam int IN_WIDTH  = 8;
    localparam int OUT_WIDTH = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PASS_SETUP,
        ST_UPDATE,
        ST_DRAIN,
        ST_READ,
        ST_READ_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic pass_start;
        logic upd_step;
        logic read_issue;
        logic finish;
    } dpc_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pass_last;
        logic upd_last;
    } dpc_status_t;

endpackage

/* rtl/distinct_partition_counter.sv */
// Distinct-part partition counter.
// Drive cube_count and raise start; the transaction is taken at a rising edge
// with start high and busy low. The block then fills a working table held in
// one memory with one write port and two registered read ports, adding one
// part per pass and updating one entry per cycle from the top down.
// The result way_count appears with done high for exactly one cycle.
// For an effective count n (inputs above MAX_N are clamped to MAX_N), the
// block initializes the table's n+1 entries, then updates the entries of
// each pass, with a drain and a setup state per pass, and ends with the
// final read of table entry n, which holds the result.
// One transaction is processed at a time; busy stays high until the result
// is produced, and a new transaction may be taken in the cycle in which done
// is high. The result is held in an output register and is not repeated.
// The receiver cannot stall the block, so done is not acknowledged.
// Reset returns the controller to idle and clears done and busy; the table
// memory is not cleared, since every item rewrites what it reads.
module distinct_partition_counter #(
    parameter int MAX_N       = 255,
    parameter int COUNT_WIDTH = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dpc_pkg::IN_WIDTH-1:0]   cube_count,
    output logic                           done,
    output logic [dpc_pkg::OUT_WIDTH-1:0]  way_count
);
    import dpc_pkg::*;

    dpc_cmd_t    cmd;
    dpc_status_t status;

    dpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    dpc_datapath #(
        .MAX_N       (MAX_N),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cube_count (cube_count),
        .status     (status),
        .done       (done),
        .way_count  (way_count)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("Accepted transaction did not make the block busy.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> !$past(start && !busy))
        else $error("Result appeared right after an accept.");

endmodule

/* rtl/dpc_ctrl.sv */
module dpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dpc_pkg::dpc_status_t status,
    output logic                busy,
    output dpc_pkg::dpc_cmd_t   cmd
);
    import dpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_PASS_SETUP;
                end
            end
            ST_PASS_SETUP:
            begin
                if (status.pass_last)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.upd_step = 1'b1;
                if (status.upd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PASS_SETUP;
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dpc_datapath.sv */
module dpc_datapath #(
    parameter int MAX_N       = 255,
    parameter int COUNT_WIDTH = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dpc_pkg::dpc_cmd_t              cmd,
    input  logic [dpc_pkg::IN_WIDTH-1:0]   cube_count,
    output dpc_pkg::dpc_status_t           status,
    output logic                           done,
    output logic [dpc_pkg::OUT_WIDTH-1:0]  way_count
);
    import dpc_pkg::*;

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N + 1) : 1;

    logic [COUNT_WIDTH-1:0] mem [0:MAX_N];

    logic [AW-1:0]          n_reg;
    logic [AW-1:0]          n_next;
    logic [AW-1:0]          k_reg;
    logic [AW-1:0]          s_reg;
    logic                   pend_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_a_reg;
    logic [COUNT_WIDTH-1:0] rd_b_reg;
    logic                   done_reg;
    logic [OUT_WIDTH-1:0]   out_reg;

    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;
    logic [63:0]            rd_a_ext;

    assign n_next = (cube_count > IN_WIDTH'(MAX_N)) ? AW'(MAX_N) : AW'(cube_count);

    assign rd_addr_a = cmd.read_issue ? n_reg : s_reg;
    assign rd_addr_b = s_reg - k_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = s_reg;
        mem_wd = COUNT_WIDTH'(s_reg == '0);
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (pend_reg)
        begin
            mem_we = 1'b1;
            mem_wa = wr_addr_reg;
            mem_wd = rd_a_reg + rd_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
            k_reg    <= '0;
            s_reg    <= '0;
        end
        else
        begin
            pend_reg <= cmd.upd_step;
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                n_reg <= n_next;
                k_reg <= '0;
                s_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                s_reg <= s_reg + AW'(1);
            end
            else if (cmd.pass_start)
            begin
                k_reg <= k_reg + AW'(1);
                s_reg <= n_reg;
            end
            else if (cmd.upd_step)
            begin
                s_reg <= s_reg - AW'(1);
            end
        end
    end

    assign rd_a_ext = 64'(rd_a_reg);

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= s_reg;
        if (cmd.finish)
        begin
            out_reg <= rd_a_ext[OUT_WIDTH-1:0];
        end
    end

    assign status.clear_last = (s_reg == n_reg);
    assign status.pass_last  = (k_reg == n_reg);
    assign status.upd_last   = (s_reg == k_reg);

    assign done      = done_reg;
    assign way_count = out_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && cmd.clear_step))
        else $error("Update write collides with a clear write.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_step |-> (s_reg >= k_reg) && (k_reg != '0))
        else $error("Update step reads below the current part.");

    a_n_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_N)
        else $error("Stored cube count exceeds the served maximum.");

endmodule
